// ----- rtl/pptr_pkg.sv -----
// ----------------------------------------------------------------------------
// pptr_pkg: shared types and constants of the phased PID temperature regulator
// Phase codes, register map, configuration and loop state bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package pptr_pkg;

	localparam int unsigned ADDR_W  = 5;
	localparam int unsigned DATA_W  = 32;
	localparam int unsigned FRAME_W = 20;
	localparam int unsigned TEMP_W  = 8;
	localparam int unsigned GAIN_W  = 8;
	localparam int unsigned DRIVE_W = 10;
	localparam int unsigned ERR_W   = 9;
	localparam int unsigned SUM_W   = 24;

	// Phase boundaries on the frame number
	localparam logic [FRAME_W-1:0] FRAME_IDLE_LAST    = 20'd10;
	localparam logic [FRAME_W-1:0] FRAME_SETTLE_FIRST = 20'd60;
	localparam logic [FRAME_W-1:0] FRAME_CAPTURE      = 20'd199;
	localparam logic [FRAME_W-1:0] FRAME_REG_FIRST    = 20'd200;

	// Register reset values
	localparam logic [GAIN_W-1:0]  GAIN_P_RST       = 8'd70;
	localparam logic [GAIN_W-1:0]  GAIN_I_RST       = 8'd1;
	localparam logic [GAIN_W-1:0]  GAIN_D_RST       = 8'd150;
	localparam logic [DRIVE_W-1:0] DRIVE_MAX_RST    = 10'd600;
	localparam logic [DRIVE_W-1:0] DRIVE_MIN_RST    = 10'd300;
	localparam logic [DRIVE_W-1:0] DRIVE_OFFSET_RST = 10'd395;

	typedef enum logic [1:0] {
		PH_IDLE    = 2'd0,
		PH_PREHEAT = 2'd1,
		PH_SETTLE  = 2'd2,
		PH_REG     = 2'd3
	} phase_t;

	typedef enum logic [2:0] {
		REG_GAIN_P       = 3'd0,
		REG_GAIN_I       = 3'd1,
		REG_GAIN_D       = 3'd2,
		REG_DRIVE_MAX    = 3'd3,
		REG_DRIVE_MIN    = 3'd4,
		REG_DRIVE_OFFSET = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic [GAIN_W-1:0]  gain_p;
		logic [GAIN_W-1:0]  gain_i;
		logic [GAIN_W-1:0]  gain_d;
		logic [DRIVE_W-1:0] drive_max;
		logic [DRIVE_W-1:0] drive_min;
		logic [DRIVE_W-1:0] drive_offset;
	} cfg_t;

	typedef struct packed {
		logic [TEMP_W-1:0]  setpoint;
		logic [SUM_W-1:0]   error_sum;
		logic [ERR_W-1:0]   previous_error;
		logic [DRIVE_W-1:0] drive;
	} loop_state_t;

endpackage

`default_nettype wire

// ----- rtl/phased_pid_temperature_regulator_unit.sv -----
// ----------------------------------------------------------------------------
// phased_pid_temperature_regulator_unit: phased PID Peltier drive regulator
// Idle, preheat, settle and regulate phases selected by the frame number;
// positional PID with saturating integrator and clamped 10-bit drive.
// ----------------------------------------------------------------------------
//
//  channel  | handshake                    | payload
//  ---------+------------------------------+-----------------------------------
//  item     | item_valid / item_ready      | frame_index[19:0], temperature[7:0]
//  result   | result_valid / result_ready  | drive_value[9:0], drive_write, phase
//  config   | psel/penable/pwrite, pready  | paddr[4:0], pwdata, prdata
//
//  Requests enter one per cycle while item_ready is high; each request is
//  staged in the input register and then moved into the result register.
//  The PID math runs combinationally between those two registers, and
//  the loop state updates at the same edge that loads the result register.
//  A stalled result register holds its request and the input register; both
//  drain as soon as result_ready returns. No clearing pass after reset.
//  Reset brings registers to their defaults and the loop state to zero.
// ----------------------------------------------------------------------------
`default_nettype none

module phased_pid_temperature_regulator_unit (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	// item request
	input  wire logic                         item_valid,
	output logic                              item_ready,
	input  wire logic [pptr_pkg::FRAME_W-1:0] frame_index,
	input  wire logic signed [pptr_pkg::TEMP_W-1:0] temperature,
	// result request
	output logic                              result_valid,
	input  wire logic                         result_ready,
	output logic      [pptr_pkg::DRIVE_W-1:0] drive_value,
	output logic                              drive_write,
	output logic      [1:0]                   phase,
	// configuration
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [pptr_pkg::ADDR_W-1:0]  paddr,
	input  wire logic [pptr_pkg::DATA_W-1:0]  pwdata,
	output logic      [pptr_pkg::DATA_W-1:0]  prdata,
	output logic                              pready
);
	import pptr_pkg::*;

	cfg_t                 cfg;
	loop_state_t          state_q;
	loop_state_t          state_nxt;

	// input register
	logic                 valid_s1;
	logic [FRAME_W-1:0]   frame_s1;
	logic [TEMP_W-1:0]    temp_s1;

	// result register
	logic                 result_valid_q;
	logic [DRIVE_W-1:0]   drive_value_q;
	logic                 drive_write_q;
	phase_t               phase_q;

	logic [DRIVE_W-1:0]   step_drive;
	logic                 step_write;
	phase_t               step_phase;
	logic                 advance;

	pptr_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	pptr_step u_step (
		.cfg         (cfg),
		.cur         (state_q),
		.frame_index (frame_s1),
		.temperature (temp_s1),
		.nxt         (state_nxt),
		.drive_value (step_drive),
		.drive_write (step_write),
		.phase       (step_phase)
	);

	// Move the staged request into the result register when that slot is free
	// or is being emptied this cycle.
	assign advance    = valid_s1 && (!result_valid_q || result_ready);
	assign item_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	// Capture the payload on acceptance; hold it otherwise
	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			frame_s1 <= frame_index;
			temp_s1  <= temperature;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			drive_value_q <= step_drive;
			drive_write_q <= step_write;
			phase_q       <= step_phase;
		end
	end

	// Loop state commits only with the request it belongs to
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	assign result_valid = result_valid_q;
	assign drive_value  = drive_value_q;
	assign drive_write  = drive_write_q;
	assign phase        = phase_q;

`ifndef SYNTH
	a_write_in_regulate: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (drive_write == (phase_q == PH_REG)))
		else $error("drive_write disagrees with the regulate phase");

	a_drive_in_limits: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && drive_write && (cfg.drive_min <= cfg.drive_max))
		|-> ((drive_value >= cfg.drive_min) && (drive_value <= cfg.drive_max)))
		else $error("regulated drive outside its clamp limits");

	a_accept_stages: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && item_ready) |=> valid_s1)
		else $error("accepted request did not reach the input register");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> item_ready)
		else $error("input register empty but item_ready low");
`endif

endmodule

`default_nettype wire

// ----- rtl/pptr_regs.sv -----
// ----------------------------------------------------------------------------
// pptr_regs: APB configuration registers
// Gains, drive limits and drive offset, written in the access phase, read back on prdata.
// ----------------------------------------------------------------------------
`default_nettype none

module pptr_regs (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [pptr_pkg::ADDR_W-1:0] paddr,
	input  wire logic [pptr_pkg::DATA_W-1:0] pwdata,
	output logic      [pptr_pkg::DATA_W-1:0] prdata,
	output logic                            pready,
	output pptr_pkg::cfg_t                  cfg
);
	import pptr_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain_p       <= GAIN_P_RST;
			cfg_q.gain_i       <= GAIN_I_RST;
			cfg_q.gain_d       <= GAIN_D_RST;
			cfg_q.drive_max    <= DRIVE_MAX_RST;
			cfg_q.drive_min    <= DRIVE_MIN_RST;
			cfg_q.drive_offset <= DRIVE_OFFSET_RST;
		end else if (wr_en) begin
			case (idx)
				REG_GAIN_P:       cfg_q.gain_p       <= pwdata[GAIN_W-1:0];
				REG_GAIN_I:       cfg_q.gain_i       <= pwdata[GAIN_W-1:0];
				REG_GAIN_D:       cfg_q.gain_d       <= pwdata[GAIN_W-1:0];
				REG_DRIVE_MAX:    cfg_q.drive_max    <= pwdata[DRIVE_W-1:0];
				REG_DRIVE_MIN:    cfg_q.drive_min    <= pwdata[DRIVE_W-1:0];
				REG_DRIVE_OFFSET: cfg_q.drive_offset <= pwdata[DRIVE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_GAIN_P:       prdata = DATA_W'(cfg_q.gain_p);
			REG_GAIN_I:       prdata = DATA_W'(cfg_q.gain_i);
			REG_GAIN_D:       prdata = DATA_W'(cfg_q.gain_d);
			REG_DRIVE_MAX:    prdata = DATA_W'(cfg_q.drive_max);
			REG_DRIVE_MIN:    prdata = DATA_W'(cfg_q.drive_min);
			REG_DRIVE_OFFSET: prdata = DATA_W'(cfg_q.drive_offset);
			default:          prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

// ----- rtl/pptr_step.sv -----
// ----------------------------------------------------------------------------
// pptr_step: one frame of the phased regulator
// Decodes the phase and forms the next loop state and the drive code.
// ----------------------------------------------------------------------------
`default_nettype none

module pptr_step (
	input  wire pptr_pkg::cfg_t               cfg,
	input  wire pptr_pkg::loop_state_t        cur,
	input  wire logic [pptr_pkg::FRAME_W-1:0] frame_index,
	input  wire logic [pptr_pkg::TEMP_W-1:0]  temperature,
	output pptr_pkg::loop_state_t             nxt,
	output logic      [pptr_pkg::DRIVE_W-1:0] drive_value,
	output logic                              drive_write,
	output pptr_pkg::phase_t                  phase
);
	import pptr_pkg::*;

	logic signed [ERR_W-1:0]   err;
	logic signed [ERR_W:0]     diff;
	logic signed [SUM_W:0]     sum_raw;
	logic signed [SUM_W-1:0]   sum_sat;
	logic signed [17:0]        prod_p;
	logic signed [32:0]        prod_i;
	logic signed [18:0]        prod_d;
	logic signed [33:0]        u_raw;
	logic signed [33:0]        u_clip;
	logic signed [33:0]        lim_max;
	logic signed [33:0]        lim_min;

	always_comb begin
		err     = $signed({cur.setpoint[TEMP_W-1], cur.setpoint})
			- $signed({temperature[TEMP_W-1], temperature});
		diff    = $signed({err[ERR_W-1], err})
			- $signed({cur.previous_error[ERR_W-1], cur.previous_error});
		sum_raw = $signed({cur.error_sum[SUM_W-1], cur.error_sum})
			+ $signed((SUM_W+1)'(err));

		// Saturate the integrator when the extra sign bit disagrees
		if (sum_raw[SUM_W] != sum_raw[SUM_W-1])
			sum_sat = sum_raw[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
		else
			sum_sat = sum_raw[SUM_W-1:0];

		prod_p = $signed({1'b0, cfg.gain_p}) * err;
		prod_i = $signed({1'b0, cfg.gain_i}) * sum_sat;
		prod_d = $signed({1'b0, cfg.gain_d}) * diff;

		u_raw = $signed({24'd0, cfg.drive_offset}) + 34'(prod_p) + 34'(prod_i) + 34'(prod_d);

		lim_max = $signed({24'd0, cfg.drive_max});
		lim_min = $signed({24'd0, cfg.drive_min});
		u_clip  = u_raw;
		if (u_clip > lim_max)
			u_clip = lim_max;
		if (u_clip < lim_min)
			u_clip = lim_min;

		nxt         = cur;
		drive_write = 1'b0;
		if (frame_index <= FRAME_IDLE_LAST) begin
			phase = PH_IDLE;
		end else if (frame_index < FRAME_SETTLE_FIRST) begin
			phase     = PH_PREHEAT;
			nxt.drive = cfg.drive_max;
		end else if (frame_index < FRAME_REG_FIRST) begin
			phase     = PH_SETTLE;
			nxt.drive = cfg.drive_offset;
			if (frame_index == FRAME_CAPTURE)
				nxt.setpoint = temperature;
		end else begin
			phase              = PH_REG;
			drive_write        = 1'b1;
			nxt.error_sum      = sum_sat;
			nxt.previous_error = err;
			nxt.drive          = u_clip[DRIVE_W-1:0];
		end
		drive_value = nxt.drive;
	end

endmodule

`default_nettype wire
